### hw/rtl/dtf_pkg.sv
// Package: shared types, character codes, status codes and the power-of-ten table.
package dtf_pkg;

  localparam int FRAC_BITS_DEF       = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  localparam int VALUE_W    = 64;
  localparam int INT_W      = 31;
  localparam int FRAC_ACC_W = 30;
  localparam int FCNT_W     = 4;

  localparam logic [INT_W-1:0] INT_MAX_VAL = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_CHAR  = 2'd1;
  localparam logic [1:0] STAT_INT_SAT   = 2'd2;
  localparam logic [1:0] STAT_FRAC_DROP = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
  } out_item_t;

  typedef enum logic {
    ST_ACCEPT,
    ST_DIVIDE
  } ctrl_state_t;

  typedef struct packed {
    logic take;    // accumulate the accepted character
    logic start;   // character ends the field: latch divider, clear field
    logic step;    // one restoring-division iteration
    logic load;    // write the result register
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  // Rank of a status code: bad character > saturated > dropped > ok.
  function automatic logic [1:0] severity(input logic [1:0] code);
    case (code)
      STAT_BAD_CHAR:  severity = 2'd3;
      STAT_INT_SAT:   severity = 2'd2;
      STAT_FRAC_DROP: severity = 2'd1;
      default:        severity = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] raise_status(input logic [1:0] cur, input logic [1:0] code);
    raise_status = (severity(code) > severity(cur)) ? code : cur;
  endfunction

  // Ten to the power n; counts above nine clamp to nine.
  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
    case (n)
      4'd0:    pow10 = 30'd1;
      4'd1:    pow10 = 30'd10;
      4'd2:    pow10 = 30'd100;
      4'd3:    pow10 = 30'd1000;
      4'd4:    pow10 = 30'd10000;
      4'd5:    pow10 = 30'd100000;
      4'd6:    pow10 = 30'd1000000;
      4'd7:    pow10 = 30'd10000000;
      4'd8:    pow10 = 30'd100000000;
      default: pow10 = 30'd1000000000;
    endcase
  endfunction

endpackage

### hw/rtl/dtf_ctrl.sv
// Controller: field accept / divide sequencing and result register handshake.
module dtf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output dtf_pkg::dp_cmd_t   cmd,
  input  dtf_pkg::dp_stat_t  stat
);

  dtf_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtf_pkg::ST_ACCEPT: begin
        if (in_valid && in_last) state_nxt = dtf_pkg::ST_DIVIDE;
      end
      dtf_pkg::ST_DIVIDE: begin
        if (stat.div_done && out_free) state_nxt = dtf_pkg::ST_ACCEPT;
      end
      default: state_nxt = dtf_pkg::ST_ACCEPT;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      dtf_pkg::ST_ACCEPT: begin
        in_ready  = 1'b1;
        cmd.take  = in_valid;
        cmd.start = in_valid && in_last;
      end
      dtf_pkg::ST_DIVIDE: begin
        cmd.step = !stat.div_done;
        cmd.load = stat.div_done && out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtf_pkg::ST_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/dtf_dp.sv
// Datapath: character accumulators, serial fraction divider and result register.
module dtf_dp #(
  parameter int FRAC_BITS       = dtf_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          ch,
  input  dtf_pkg::dp_cmd_t    cmd,
  output dtf_pkg::dp_stat_t   stat,
  output dtf_pkg::out_item_t  out_item
);

  localparam int DCNT_W = $clog2(FRAC_BITS + 1);
  localparam int IW     = dtf_pkg::INT_W;
  localparam int FW     = dtf_pkg::FRAC_ACC_W;
  localparam int CW     = dtf_pkg::FCNT_W;
  localparam int VW     = dtf_pkg::VALUE_W;

  // field state
  logic [IW-1:0] int_r, int_nxt;
  logic [FW-1:0] frac_r, frac_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic          point_r, point_nxt;
  logic          neg_r, neg_nxt;
  logic          start_r, start_nxt;
  logic [1:0]    status_r, status_nxt;

  // divider state
  logic [FW-1:0]        rem_r, rem_nxt;
  logic [FW-1:0]        dvs_r, dvs_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [DCNT_W-1:0]    dcnt_r, dcnt_nxt;
  logic [IW-1:0]        hold_int_r, hold_int_nxt;
  logic                 hold_neg_r, hold_neg_nxt;
  logic [1:0]           hold_stat_r, hold_stat_nxt;

  dtf_pkg::out_item_t out_r, out_nxt;

  logic [3:0]    digit;
  logic [IW+3:0] int_prod;
  logic [FW:0]   rem2;
  logic [VW-1:0] mag;

  assign digit    = 4'(ch - dtf_pkg::CH_ZERO);
  assign int_prod = ({4'b0, int_r} << 3) + ({4'b0, int_r} << 1) + (IW+4)'(digit);

  // field accumulation
  always_comb begin
    int_nxt    = int_r;
    frac_nxt   = frac_r;
    fcnt_nxt   = fcnt_r;
    point_nxt  = point_r;
    neg_nxt    = neg_r;
    start_nxt  = start_r;
    status_nxt = status_r;
    if (cmd.take) begin
      start_nxt = 1'b0;
      if (start_r && (ch == dtf_pkg::CH_MINUS || ch == dtf_pkg::CH_PLUS)) begin
        neg_nxt = (ch == dtf_pkg::CH_MINUS);
      end else if (ch == dtf_pkg::CH_POINT) begin
        if (point_r) status_nxt = dtf_pkg::raise_status(status_r, dtf_pkg::STAT_BAD_CHAR);
        else         point_nxt  = 1'b1;
      end else if (ch inside {[dtf_pkg::CH_ZERO:dtf_pkg::CH_NINE]}) begin
        if (!point_r) begin
          if (int_prod > (IW+4)'(dtf_pkg::INT_MAX_VAL)) begin
            int_nxt    = dtf_pkg::INT_MAX_VAL;
            status_nxt = dtf_pkg::raise_status(status_r, dtf_pkg::STAT_INT_SAT);
          end else begin
            int_nxt = int_prod[IW-1:0];
          end
        end else if (fcnt_r < CW'(MAX_FRAC_DIGITS)) begin
          frac_nxt = (frac_r << 3) + (frac_r << 1) + FW'(digit);
          fcnt_nxt = fcnt_r + 1'b1;
        end else begin
          status_nxt = dtf_pkg::raise_status(status_r, dtf_pkg::STAT_FRAC_DROP);
        end
      end else begin
        status_nxt = dtf_pkg::raise_status(status_r, dtf_pkg::STAT_BAD_CHAR);
      end
    end
  end

  // restoring division of frac * 2^FRAC_BITS by 10^count, one quotient bit per step
  assign rem2 = {rem_r, 1'b0};

  always_comb begin
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    hold_int_nxt  = hold_int_r;
    hold_neg_nxt  = hold_neg_r;
    hold_stat_nxt = hold_stat_r;
    if (cmd.start) begin
      // take the post-character totals, the last character included
      rem_nxt       = frac_nxt;
      dvs_nxt       = dtf_pkg::pow10(fcnt_nxt);
      quo_nxt       = '0;
      dcnt_nxt      = DCNT_W'(FRAC_BITS);
      hold_int_nxt  = int_nxt;
      hold_neg_nxt  = neg_nxt;
      hold_stat_nxt = status_nxt;
    end else if (cmd.step) begin
      dcnt_nxt = dcnt_r - 1'b1;
      if (rem2 >= {1'b0, dvs_r}) begin
        rem_nxt = FW'(rem2 - {1'b0, dvs_r});
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem2[FW-1:0];
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // frac * 2^F / 10^n < 2^F, so the quotient fills the fraction bits alone
  assign mag = (VW'(hold_int_r) << FRAC_BITS) | VW'(quo_r);

  always_comb begin
    out_nxt = out_r;
    if (cmd.load) begin
      out_nxt.value  = hold_neg_r ? -mag : mag;
      out_nxt.status = hold_stat_r;
    end
  end

  assign stat.div_done = (dcnt_r == '0);
  assign out_item      = out_r;

  // the field's totals move to the divider on the ending character; clear the
  // accumulators for the next field at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r    <= '0;
      frac_r   <= '0;
      fcnt_r   <= '0;
      point_r  <= 1'b0;
      neg_r    <= 1'b0;
      start_r  <= 1'b1;
      status_r <= dtf_pkg::STAT_OK;
      dcnt_r   <= '0;
    end else begin
      if (cmd.start) begin
        int_r    <= '0;
        frac_r   <= '0;
        fcnt_r   <= '0;
        point_r  <= 1'b0;
        neg_r    <= 1'b0;
        start_r  <= 1'b1;
        status_r <= dtf_pkg::STAT_OK;
      end else begin
        int_r    <= int_nxt;
        frac_r   <= frac_nxt;
        fcnt_r   <= fcnt_nxt;
        point_r  <= point_nxt;
        neg_r    <= neg_nxt;
        start_r  <= start_nxt;
        status_r <= status_nxt;
      end
      dcnt_r   <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    quo_r       <= quo_nxt;
    hold_int_r  <= hold_int_nxt;
    hold_neg_r  <= hold_neg_nxt;
    hold_stat_r <= hold_stat_nxt;
    out_r       <= out_nxt;
  end

endmodule

### hw/rtl/decimal_text_to_fixed_top.sv
// Top level: decimal text field to signed fixed point converter.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------------
//   input   | in_valid, in_ready, in_item    | one character item, with last mark
//   result  | out_valid, out_ready, out_item | one Q(63-F).F value and status item
//
// Sequencing: characters are taken while the block is in its accept phase. The item
// that carries the last mark starts a restoring divider that produces one quotient bit
// per cycle, and in_ready stays low until the divider is done and the result is
// loaded. The divider is the only multi-cycle unit.
// Reset: synchronous, active low; clears the field state and the result valid.
// Stalls: a held result does not block the next field's characters; only the end
// of a field waits for the result register to free up before it is written.
module decimal_text_to_fixed_top #(
  parameter int FRAC_BITS       = dtf_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtf_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dtf_pkg::out_item_t  out_item
);

  // command and status between the sequencer and the datapath
  dtf_pkg::dp_cmd_t  cmd;
  dtf_pkg::dp_stat_t stat;

  // sequence the accept and divide phases, own the result valid
  dtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_item.last),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // accumulate digits, divide the fraction, hold the result
  dtf_dp #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ch       (in_item.ch),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

### tb/decimal_text_to_fixed_top_tb.sv
// Testbench for decimal_text_to_fixed_top: random decimal fields checked against a predictor.
`timescale 1ns / 100ps

module decimal_text_to_fixed_top_tb;

  localparam int FRAC_BITS  = dtf_pkg::FRAC_BITS_DEF;
  localparam int KEPT_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF;
  localparam logic [63:0] SAT_LIMIT = 64'd2147483647;
  // Covers the divider's run after the last character, with margin.
  localparam int SETTLE_CYCLES = FRAC_BITS + 16;

  // Field converter predictor plus the queue of results it has produced but
  // the block has not delivered yet.
  class fixed_scoreboard;
    logic [30:0]        whole_acc;
    logic [29:0]        frac_part;
    int                 frac_digits;
    bit                 point_seen;
    bit                 neg;
    bit                 fresh;
    logic [1:0]         status_acc;
    dtf_pkg::out_item_t expected_q[$];
    int                 errors;

    function new();
      errors = 0;
      clear_field();
    endfunction

    function void clear_field();
      whole_acc   = '0;
      frac_part   = '0;
      frac_digits = 0;
      point_seen  = 0;
      neg         = 0;
      fresh       = 1;
      status_acc  = dtf_pkg::STAT_OK;
    endfunction

    function int rank(logic [1:0] code);
      case (code)
        dtf_pkg::STAT_BAD_CHAR:  return 3;
        dtf_pkg::STAT_INT_SAT:   return 2;
        dtf_pkg::STAT_FRAC_DROP: return 1;
        default:                 return 0;
      endcase
    endfunction

    function void bump(logic [1:0] code);
      if (rank(code) > rank(status_acc)) status_acc = code;
    endfunction

    function logic [63:0] ten_pow(int n);
      logic [63:0] p;
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      return p;
    endfunction

    function void note_char(dtf_pkg::in_item_t it);
      logic [7:0]         c;
      logic [63:0]        wide;
      logic [63:0]        frac_term;
      logic [63:0]        mag;
      bit                 is_first;
      dtf_pkg::out_item_t res;
      c        = it.ch;
      is_first = fresh;
      fresh    = 0;
      if (is_first && (c == dtf_pkg::CH_MINUS || c == dtf_pkg::CH_PLUS)) begin
        neg = (c == dtf_pkg::CH_MINUS);
      end else if (c == dtf_pkg::CH_POINT) begin
        if (point_seen) bump(dtf_pkg::STAT_BAD_CHAR);
        else point_seen = 1;
      end else if (c >= dtf_pkg::CH_ZERO && c <= dtf_pkg::CH_NINE) begin
        if (!point_seen) begin
          wide = 64'(whole_acc) * 64'd10 + 64'(c - dtf_pkg::CH_ZERO);
          if (wide > SAT_LIMIT) begin
            whole_acc = SAT_LIMIT[30:0];
            bump(dtf_pkg::STAT_INT_SAT);
          end else begin
            whole_acc = wide[30:0];
          end
        end else if (frac_digits < KEPT_DIGITS) begin
          frac_part   = 30'(frac_part * 30'd10 + 30'(c - dtf_pkg::CH_ZERO));
          frac_digits = frac_digits + 1;
        end else begin
          bump(dtf_pkg::STAT_FRAC_DROP);
        end
      end else begin
        bump(dtf_pkg::STAT_BAD_CHAR);
      end
      if (it.last) begin
        frac_term  = (64'(frac_part) << FRAC_BITS) / ten_pow(frac_digits);
        mag        = (64'(whole_acc) << FRAC_BITS) + frac_term;
        res.value  = neg ? -mag : mag;
        res.status = status_acc;
        expected_q.push_back(res);
        clear_field();
      end
    endfunction

    function void check_result(dtf_pkg::out_item_t got);
      dtf_pkg::out_item_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0d status %0d", got.value, got.status);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.value !== exp_res.value) begin
        $error("value: expected %0d, actual %0d", exp_res.value, got.value);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  dtf_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  dtf_pkg::out_item_t out_item;

  fixed_scoreboard sb = new();

  // Idle odds in percent, changed per phase by the stimulus process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chars_sent     = 0;

  decimal_text_to_fixed_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop: far beyond any legal run, even one ending every character
  // under the heaviest stalls.
  initial begin
    #2000000;
    $display("decimal_text_to_fixed_top_tb NOT OK");
    $finish;
  end

  // Watch both channels at the clock edge; values seen here are pre-edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_char(in_item);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // Receiver: stall at random with the current phase's odds.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one character; idle first with the phase's odds, then hold until taken.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= dtf_pkg::in_item_t'{ch: c, last: is_last};
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // Send a whole field; the last character carries the end mark.
  task automatic send_field(input logic [7:0] chars[$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] chars[$];
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    send_field(chars);
  endtask

  // Mostly well-formed numbers with random content; some broken or pure noise.
  task automatic send_random_field();
    logic [7:0] chars[$];
    int         n_int;
    int         n_frac;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // noise: any byte at all
      repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(2))
        0: ;
        1: chars.push_back(dtf_pkg::CH_MINUS);
        default: chars.push_back(dtf_pkg::CH_PLUS);
      endcase
      n_int = ($urandom_range(3) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 9);
      repeat (n_int) chars.push_back(8'(dtf_pkg::CH_ZERO + $urandom_range(9)));
      if ($urandom_range(9) < 7) begin
        chars.push_back(dtf_pkg::CH_POINT);
        n_frac = ($urandom_range(4) == 0) ? $urandom_range(10, 11) : $urandom_range(0, 9);
        repeat (n_frac) chars.push_back(8'(dtf_pkg::CH_ZERO + $urandom_range(9)));
      end
      if (chars.size() == 0) chars.push_back(dtf_pkg::CH_ZERO);
      // break some fields: stray sign, extra point or any byte inserted in the field
      if (pick >= 85) begin
        case ($urandom_range(2))
          0: chars.insert($urandom_range(chars.size()), dtf_pkg::CH_POINT);
          1: chars.insert($urandom_range(1, chars.size()), dtf_pkg::CH_MINUS);
          default: chars.insert($urandom_range(chars.size()), 8'($urandom_range(255)));
        endcase
      end
    end
    send_field(chars);
  endtask

  // Hold the sender low until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lone sign, plus with bare point, saturated integer, dropped
    // fraction digits, second point, sign not at field start, byte extremes.
    send_text("-");
    send_text("+.");
    send_text("9999999999");
    send_text("-.1234567890");
    send_text("1.2.");
    send_field('{8'h00, dtf_pkg::CH_MINUS});
    send_field('{8'hFF});

    // Phases: no idling, sender idle, receiver stalls, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      while (chars_sent < (phase + 1) * 250) send_random_field();
      // Let the pipeline empty out before the receiver starts stalling.
      if (phase == 1) wait_drained();
    end
    in_valid <= 1'b0;

    // Drain, then give a late or stray result the chance to show up.
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("decimal_text_to_fixed_top_tb OK");
    end else begin
      $display("decimal_text_to_fixed_top_tb NOT OK");
    end
    $finish;
  end

endmodule
